>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the instruction executor.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MSIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true outside reset.
`define MSIE_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hw/rtl/msie_pkg.sv
// Package for the instruction executor: sizes, opcodes, function codes,
// state encodings and the structs passed between modules. No dependencies.
package msie_pkg;

  localparam int DATA_BYTES = 1024;
  localparam int MEM_WORDS  = (DATA_BYTES + 3) / 4;
  localparam int MEM_AW     = $clog2(MEM_WORDS);

  localparam logic [31:0] LIM_BYTE = 32'(DATA_BYTES - 1);
  localparam logic [31:0] LIM_HALF = 32'(DATA_BYTES - 2);
  localparam logic [31:0] LIM_WORD = 32'(DATA_BYTES - 4);

  localparam logic CFG_START_PC = 1'b0;
  localparam logic CFG_START_SP = 1'b1;

  typedef enum logic [1:0] {
    FN_EXEC    = 2'd0,
    FN_MEMW    = 2'd1,
    FN_RESTART = 2'd2,
    FN_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MEM
  } state_t;

  typedef enum logic [1:0] {
    SZ_BYTE,
    SZ_HALF,
    SZ_WORD
  } msize_t;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_BGTZ  = 6'h07;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0A;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_NORI  = 6'h0E;
  localparam logic [5:0] OP_LUI   = 6'h0F;
  localparam logic [5:0] OP_LB    = 6'h20;
  localparam logic [5:0] OP_LH    = 6'h21;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2B;

  localparam logic [5:0] FC_SLL   = 6'h00;
  localparam logic [5:0] FC_SRL   = 6'h02;
  localparam logic [5:0] FC_SRA   = 6'h03;
  localparam logic [5:0] FC_JR    = 6'h08;
  localparam logic [5:0] FC_MFHI  = 6'h10;
  localparam logic [5:0] FC_MFLO  = 6'h12;
  localparam logic [5:0] FC_MULT  = 6'h18;
  localparam logic [5:0] FC_MULTU = 6'h19;
  localparam logic [5:0] FC_ADD   = 6'h20;
  localparam logic [5:0] FC_ADDU  = 6'h21;
  localparam logic [5:0] FC_SUB   = 6'h22;
  localparam logic [5:0] FC_AND   = 6'h24;
  localparam logic [5:0] FC_OR    = 6'h25;
  localparam logic [5:0] FC_XOR   = 6'h26;
  localparam logic [5:0] FC_NOR   = 6'h27;
  localparam logic [5:0] FC_NAND  = 6'h28;
  localparam logic [5:0] FC_SLT   = 6'h2A;

  typedef struct packed {
    logic        dowr;
    logic [4:0]  dest;
    logic [31:0] val;
    logic [31:0] npc;
    logic        ovf;
    logic        ldz;
    logic        halt;
    logic        mem;
    logic        load;
    logic        sgn;
    msize_t      size;
    logic [31:0] addr;
    logic        aovf;
    logic        mis;
    logic        mul;
    logic [63:0] prod;
    logic        rd_hilo;
  } exec_res_t;

  typedef struct packed {
    logic              load;
    logic              sgn;
    msize_t            size;
    logic [4:0]        rt;
    logic [1:0]        lane;
    logic [MEM_AW-1:0] widx;
    logic [31:0]       b;
    logic              ovf;
    logic              ldz;
  } mem_req_t;

endpackage

>>> hw/rtl/msie_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module msie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [WIDTH-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

>>> hw/rtl/msie_exec.sv
// Instruction decode and execute for one instruction with resolved operands.
// Depends on msie_pkg.
module msie_exec (
  input  logic [31:0]         ins,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  input  logic [31:0]         pc,
  input  logic [31:0]         hi,
  input  logic [31:0]         lo,
  output msie_pkg::exec_res_t res
);
  import msie_pkg::*;

  logic [5:0]         op;
  logic [5:0]         fn;
  logic [4:0]         rt;
  logic [4:0]         rd;
  logic [4:0]         sh;
  logic [31:0]        imm;
  logic [31:0]        zimm;
  logic [31:0]        pc4;
  logic [31:0]        sum_rr;
  logic [31:0]        dif_rr;
  logic [31:0]        sum_ri;
  logic               ovf_ri;
  logic signed [65:0] prod_w;

  assign op     = ins[31:26];
  assign fn     = ins[5:0];
  assign rt     = ins[20:16];
  assign rd     = ins[15:11];
  assign sh     = ins[10:6];
  assign imm    = {{16{ins[15]}}, ins[15:0]};
  assign zimm   = {16'h0000, ins[15:0]};
  assign pc4    = pc + 32'd4;
  assign sum_rr = a + b;
  assign dif_rr = a - b;
  assign sum_ri = a + imm;
  assign ovf_ri = ~(a[31] ^ imm[31]) & (a[31] ^ sum_ri[31]);
  assign prod_w = $signed({fn == FC_MULT && a[31], a}) * $signed({fn == FC_MULT && b[31], b});

  always_comb begin
    res      = '0;
    res.npc  = pc4;
    res.size = SZ_WORD;
    res.prod = prod_w[63:0];
    case (op)
      OP_RTYPE: begin
        case (fn)
          FC_ADD: begin
            res.val  = sum_rr;
            res.ovf  = ~(a[31] ^ b[31]) & (a[31] ^ sum_rr[31]);
            res.dowr = 1'b1;
          end
          FC_ADDU: begin
            res.val  = sum_rr;
            res.dowr = 1'b1;
          end
          FC_SUB: begin
            res.val  = dif_rr;
            res.ovf  = (a[31] ^ b[31]) & (a[31] ^ dif_rr[31]);
            res.dowr = 1'b1;
          end
          FC_AND: begin
            res.val  = a & b;
            res.dowr = 1'b1;
          end
          FC_OR: begin
            res.val  = a | b;
            res.dowr = 1'b1;
          end
          FC_XOR: begin
            res.val  = a ^ b;
            res.dowr = 1'b1;
          end
          FC_NOR: begin
            res.val  = ~(a | b);
            res.dowr = 1'b1;
          end
          FC_NAND: begin
            res.val  = ~(a & b);
            res.dowr = 1'b1;
          end
          FC_SLT: begin
            res.val  = {31'd0, $signed(a) < $signed(b)};
            res.dowr = 1'b1;
          end
          FC_SLL: begin
            res.val  = b << sh;
            res.dowr = (rd != 5'd0) || (rt != 5'd0) || (sh != 5'd0);
          end
          FC_SRL: begin
            res.val  = b >> sh;
            res.dowr = 1'b1;
          end
          FC_SRA: begin
            res.val  = 32'($signed(b) >>> sh);
            res.dowr = 1'b1;
          end
          FC_JR: begin
            res.npc = a;
          end
          FC_MULT, FC_MULTU: begin
            res.mul = 1'b1;
          end
          FC_MFHI: begin
            res.val     = hi;
            res.rd_hilo = 1'b1;
            res.dowr    = 1'b1;
          end
          FC_MFLO: begin
            res.val     = lo;
            res.rd_hilo = 1'b1;
            res.dowr    = 1'b1;
          end
          default: begin
            res.halt = 1'b1;
          end
        endcase
        res.dest = rd;
      end
      OP_ADDI, OP_ADDIU: begin
        res.val  = sum_ri;
        res.ovf  = (op == OP_ADDI) && ovf_ri;
        res.dest = rt;
        res.dowr = 1'b1;
      end
      OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW: begin
        res.mem  = 1'b1;
        res.load = !op[3];
        res.sgn  = !op[2];
        res.addr = sum_ri;
        res.ovf  = ovf_ri;
        res.ldz  = !op[3] && (rt == 5'd0);
        case (op)
          OP_LW, OP_SW: begin
            res.size = SZ_WORD;
            res.aovf = sum_ri > LIM_WORD;
            res.mis  = |sum_ri[1:0];
          end
          OP_LH, OP_LHU, OP_SH: begin
            res.size = SZ_HALF;
            res.aovf = sum_ri > LIM_HALF;
            res.mis  = sum_ri[0];
          end
          default: begin
            res.size = SZ_BYTE;
            res.aovf = sum_ri > LIM_BYTE;
          end
        endcase
        res.halt = res.aovf || res.mis;
      end
      OP_LUI: begin
        res.val  = {ins[15:0], 16'h0000};
        res.dest = rt;
        res.dowr = 1'b1;
      end
      OP_ANDI: begin
        res.val  = a & zimm;
        res.dest = rt;
        res.dowr = 1'b1;
      end
      OP_ORI: begin
        res.val  = a | zimm;
        res.dest = rt;
        res.dowr = 1'b1;
      end
      OP_NORI: begin
        res.val  = ~(a | zimm);
        res.dest = rt;
        res.dowr = 1'b1;
      end
      OP_SLTI: begin
        res.val  = {31'd0, $signed(a) < $signed(imm)};
        res.dest = rt;
        res.dowr = 1'b1;
      end
      OP_BEQ, OP_BNE, OP_BGTZ: begin
        if ((op == OP_BEQ && a == b) || (op == OP_BNE && a != b) ||
            (op == OP_BGTZ && a != 32'd0 && !a[31])) begin
          res.npc = pc4 + {imm[29:0], 2'b00};
        end
      end
      OP_J, OP_JAL: begin
        res.npc  = {pc4[31:28], ins[25:0], 2'b00};
        res.val  = pc4;
        res.dest = 5'd31;
        res.dowr = (op == OP_JAL);
      end
      default: begin
        res.halt = 1'b1;
      end
    endcase
    if (res.halt) begin
      res.npc = pc;
    end
  end

endmodule

>>> hw/rtl/mips_subset_instruction_executor_top.sv
// Top level of the instruction executor: handshakes, sequencer, register
// file and data memory. Depends on msie_pkg, msie_ram, msie_exec, assert_macros.svh.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    func, instruction_word, mem_index, mem_word
// out      output     out_valid / out_ready  next_pc, reg_*, hi_word, lo_word, err_*, halted
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Register reads are issued at the request's accept edge; a load or store
// issues its data memory read in the cycle after.
// Most requests complete in the execute state; loads and stores without a fault
// go on to a memory state for the data memory read and write back.
// The next request is accepted in the cycle the current one completes, so the
// block takes no new request before the current one is through.
// A stalled output holds completion and input acceptance. No clearing pass
// after reset.
module mips_subset_instruction_executor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [31:0] instruction_word,
  input  logic [7:0]  mem_index,
  input  logic [31:0] mem_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] next_pc,
  output logic        reg_written,
  output logic [4:0]  reg_index,
  output logic [31:0] reg_value,
  output logic [31:0] hi_word,
  output logic [31:0] lo_word,
  output logic        err_write_zero,
  output logic        err_number_overflow,
  output logic        err_overwrite_hilo,
  output logic        err_address_overflow,
  output logic        err_misaligned,
  output logic        halted,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import msie_pkg::*;

  `include "assert_macros.svh"

  state_t            state;
  state_t            state_next;
  logic [31:0]       start_pc;
  logic [31:0]       start_sp;
  logic [31:0]       sp_rst;
  logic [31:0]       pc;
  logic [31:0]       pc_next;
  logic [31:0]       hi;
  logic [31:0]       hi_next;
  logic [31:0]       lo;
  logic [31:0]       lo_next;
  logic              unread;
  logic              unread_next;
  logic              stopped;
  logic              halt_next;
  logic [31:0]       rf_vld;
  logic [MEM_WORDS-1:0] dm_vld;

  func_t             func_q;
  logic [31:0]       ins_q;
  logic [7:0]        midx_q;
  logic [31:0]       mword_q;
  logic              fa_hit;
  logic              fb_hit;
  logic [31:0]       fwd_val;
  mem_req_t          mq;

  logic              acc;
  logic              out_free;
  logic              fin_ex;
  logic              fin_mem;
  logic              act;
  logic              go_mem;
  logic [31:0]       ram_a;
  logic [31:0]       ram_b;
  logic [31:0]       op_a;
  logic [31:0]       op_b;
  exec_res_t         ex;

  logic              rf_we;
  logic [4:0]        rf_wa;
  logic [31:0]       rf_wd;
  logic              dm_we;
  logic [MEM_AW-1:0] dm_wa;
  logic [31:0]       dm_wd;
  logic              dm_re;
  logic [31:0]       dm_rd;
  logic [31:0]       dword;
  logic [4:0]        bsh;
  logic [7:0]        ld_byte;
  logic [15:0]       ld_half;
  logic [31:0]       ld_val;
  logic [31:0]       st_mask;
  logic [31:0]       st_dat;

  logic              o_wr;
  logic [4:0]        o_idx;
  logic [31:0]       o_val;
  logic              o_wz;
  logic              o_ovf;
  logic              o_ohl;
  logic              o_aovf;
  logic              o_mis;

  assign cfg_ready = 1'b1;
  assign acc       = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign act       = (func_q == FN_EXEC) && !stopped && (pc >= start_pc);
  assign go_mem    = act && ex.mem && !ex.halt;

  msie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk (clk),
    .we  (rf_we),
    .wa  (rf_wa),
    .wd  (rf_wd),
    .re  (acc),
    .ra  (instruction_word[25:21]),
    .rd  (ram_a)
  );

  msie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk (clk),
    .we  (rf_we),
    .wa  (rf_wa),
    .wd  (rf_wd),
    .re  (acc),
    .ra  (instruction_word[20:16]),
    .rd  (ram_b)
  );

  msie_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
    .clk (clk),
    .we  (dm_we),
    .wa  (dm_wa),
    .wd  (dm_wd),
    .re  (dm_re),
    .ra  (ex.addr[MEM_AW+1:2]),
    .rd  (dm_rd)
  );

  always_comb begin
    if (fa_hit) begin
      op_a = fwd_val;
    end else if (rf_vld[ins_q[25:21]]) begin
      op_a = ram_a;
    end else if (ins_q[25:21] == 5'd29) begin
      op_a = sp_rst;
    end else begin
      op_a = '0;
    end
    if (fb_hit) begin
      op_b = fwd_val;
    end else if (rf_vld[ins_q[20:16]]) begin
      op_b = ram_b;
    end else if (ins_q[20:16] == 5'd29) begin
      op_b = sp_rst;
    end else begin
      op_b = '0;
    end
  end

  msie_exec u_exec (
    .ins (ins_q),
    .a   (op_a),
    .b   (op_b),
    .pc  (pc),
    .hi  (hi),
    .lo  (lo),
    .res (ex)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (go_mem) begin
          state_next = ST_MEM;
        end else if (out_free) begin
          state_next = in_valid ? ST_EXEC : ST_IDLE;
        end
      end
      ST_MEM: begin
        if (out_free) begin
          state_next = in_valid ? ST_EXEC : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    fin_ex  = 1'b0;
    fin_mem = 1'b0;
    dm_re   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_EXEC: begin
        fin_ex   = !go_mem && out_free;
        dm_re    = go_mem;
        in_ready = fin_ex;
      end
      ST_MEM: begin
        fin_mem  = out_free;
        in_ready = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign dword   = dm_vld[mq.widx] ? dm_rd : '0;
  assign bsh     = {~mq.lane, 3'b000};
  assign ld_byte = dword[bsh +: 8];
  assign ld_half = mq.lane[1] ? dword[15:0] : dword[31:16];

  always_comb begin
    case (mq.size)
      SZ_BYTE: begin
        ld_val  = {{24{mq.sgn && ld_byte[7]}}, ld_byte};
        st_mask = 32'h0000_00FF << bsh;
        st_dat  = {24'd0, mq.b[7:0]} << bsh;
      end
      SZ_HALF: begin
        ld_val  = {{16{mq.sgn && ld_half[15]}}, ld_half};
        st_mask = mq.lane[1] ? 32'h0000_FFFF : 32'hFFFF_0000;
        st_dat  = {2{mq.b[15:0]}};
      end
      default: begin
        ld_val  = dword;
        st_mask = 32'hFFFF_FFFF;
        st_dat  = mq.b;
      end
    endcase
  end

  always_comb begin
    rf_we = 1'b0;
    rf_wa = ex.dest;
    rf_wd = ex.val;
    dm_we = 1'b0;
    dm_wa = MEM_AW'(midx_q);
    dm_wd = mword_q;
    if (fin_ex && act && ex.dowr && ex.dest != 5'd0 && !ex.halt) begin
      rf_we = 1'b1;
    end
    if (fin_ex && func_q == FN_MEMW && 32'(midx_q) < MEM_WORDS) begin
      dm_we = 1'b1;
    end
    if (fin_mem) begin
      if (mq.load) begin
        rf_we = mq.rt != 5'd0;
        rf_wa = mq.rt;
        rf_wd = ld_val;
      end else begin
        dm_we = 1'b1;
        dm_wa = mq.widx;
        dm_wd = (dword & ~st_mask) | (st_dat & st_mask);
      end
    end
  end

  always_comb begin
    pc_next     = pc;
    hi_next     = hi;
    lo_next     = lo;
    unread_next = unread;
    halt_next   = stopped;
    o_wr        = 1'b0;
    o_idx       = '0;
    o_val       = '0;
    o_wz        = 1'b0;
    o_ovf       = 1'b0;
    o_ohl       = 1'b0;
    o_aovf      = 1'b0;
    o_mis       = 1'b0;
    if (fin_mem) begin
      pc_next = pc + 32'd4;
      o_wr    = rf_we;
      o_idx   = rf_we ? mq.rt : 5'd0;
      o_val   = rf_we ? ld_val : 32'd0;
      o_wz    = mq.ldz;
      o_ovf   = mq.ovf;
    end else if (fin_ex) begin
      case (func_q)
        FN_EXEC: begin
          if (!stopped) begin
            if (!act) begin
              pc_next = pc + 32'd4;
            end else begin
              pc_next = ex.npc;
              o_wr    = rf_we;
              o_idx   = rf_we ? ex.dest : 5'd0;
              o_val   = rf_we ? ex.val : 32'd0;
              o_wz    = (ex.dowr && ex.dest == 5'd0) || ex.ldz;
              o_ovf   = ex.ovf;
              o_aovf  = ex.aovf;
              o_mis   = ex.mis;
              if (ex.halt) begin
                halt_next = 1'b1;
              end
              if (ex.mul) begin
                hi_next     = ex.prod[63:32];
                lo_next     = ex.prod[31:0];
                o_ohl       = unread;
                unread_next = 1'b1;
              end
              if (ex.rd_hilo) begin
                unread_next = 1'b0;
              end
            end
          end
        end
        FN_RESTART: begin
          pc_next     = start_pc;
          hi_next     = '0;
          lo_next     = '0;
          unread_next = 1'b0;
          halt_next   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      start_pc  <= '0;
      start_sp  <= '0;
      sp_rst    <= '0;
      pc        <= '0;
      hi        <= '0;
      lo        <= '0;
      unread    <= 1'b0;
      stopped   <= 1'b0;
      rf_vld    <= '0;
      dm_vld    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      hi        <= hi_next;
      lo        <= lo_next;
      unread    <= unread_next;
      stopped   <= halt_next;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_START_PC: start_pc <= cfg_data;
          CFG_START_SP: start_sp <= cfg_data;
          default: begin
          end
        endcase
      end
      if (fin_ex && func_q == FN_RESTART) begin
        sp_rst <= start_sp;
        rf_vld <= '0;
      end else if (rf_we) begin
        rf_vld[rf_wa] <= 1'b1;
      end
      if (dm_we) begin
        dm_vld[dm_wa] <= 1'b1;
      end
      if (fin_ex || fin_mem) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      func_q  <= func_t'(func);
      ins_q   <= instruction_word;
      midx_q  <= mem_index;
      mword_q <= mem_word;
      fa_hit  <= rf_we && (rf_wa == instruction_word[25:21]);
      fb_hit  <= rf_we && (rf_wa == instruction_word[20:16]);
      fwd_val <= rf_wd;
    end
    if (go_mem && state == ST_EXEC) begin
      mq.load <= ex.load;
      mq.sgn  <= ex.sgn;
      mq.size <= ex.size;
      mq.rt   <= ins_q[20:16];
      mq.lane <= ex.addr[1:0];
      mq.widx <= ex.addr[MEM_AW+1:2];
      mq.b    <= op_b;
      mq.ovf  <= ex.ovf;
      mq.ldz  <= ex.ldz;
    end
    if (fin_ex || fin_mem) begin
      next_pc              <= pc_next;
      reg_written          <= o_wr;
      reg_index            <= o_idx;
      reg_value            <= o_val;
      hi_word              <= hi_next;
      lo_word              <= lo_next;
      err_write_zero       <= o_wz;
      err_number_overflow  <= o_ovf;
      err_overwrite_hilo   <= o_ohl;
      err_address_overflow <= o_aovf;
      err_misaligned       <= o_mis;
      halted               <= halt_next;
    end
  end

  `MSIE_ASSERT_NEVER(a_no_r0_write, rf_we && rf_wa == 5'd0, "register zero written")
  `MSIE_ASSERT_NEVER(a_one_mem_write, dm_we && rf_we, "memory and register written together")
  `MSIE_ASSERT(a_mem_from_exec, state == ST_MEM |-> $past(state) != ST_IDLE, "memory stage early")
  `MSIE_ASSERT(a_halt_quiet, stopped && fin_ex && func_q == FN_EXEC |-> !rf_we && !dm_we && pc_next == pc, "halted machine changed state")

endmodule
